// ===== rtl/utf8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-4 stream decoder.
// No dependencies; imported by utf8dec_core and the top level.
package utf8dec_pkg;

  localparam int BYTE_W       = 8;
  localparam int CODE_W       = 31;
  localparam int TOTAL_W      = 16;
  localparam int WCLASS_W     = 3;
  localparam int PEND_W       = 3;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CODE_W-1:0] WIDE4_MIN = CODE_W'('h10000);
  localparam logic [CODE_W-1:0] WIDE2_MAX = CODE_W'('h100);

  localparam logic [WCLASS_W-1:0] WCLASS_NONE = 3'd0;
  localparam logic [WCLASS_W-1:0] WCLASS_1    = 3'd1;
  localparam logic [WCLASS_W-1:0] WCLASS_2    = 3'd2;
  localparam logic [WCLASS_W-1:0] WCLASS_4    = 3'd4;

  typedef struct packed {
    logic                char_valid;
    logic [CODE_W-1:0]   code_point;
    logic                malformed;
    logic                string_done;
    logic                str_ok;
    logic [TOTAL_W-1:0]  char_total;
    logic [WCLASS_W-1:0] width_class;
  } result_t;

  function automatic logic [WCLASS_W-1:0] width_of(input logic [CODE_W-1:0] largest);
    if (largest >= WIDE4_MIN) return WCLASS_4;
    if (largest > WIDE2_MAX)  return WCLASS_2;
    return WCLASS_1;
  endfunction

endpackage

// ===== rtl/utf8dec_core.sv =====
// Byte decode and per-string running state: sequence accumulator, pending
// count, character counter, largest code point and error flag. Uses utf8dec_pkg.
module utf8dec_core #(
  parameter int COUNT_BITS = utf8dec_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic [utf8dec_pkg::BYTE_W-1:0]  byte_value,
  input  logic                            string_end,
  output logic                            has_result,
  output utf8dec_pkg::result_t            result
);
  import utf8dec_pkg::*;

  logic [CODE_W-1:0]     acc_r, acc_nxt;
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CODE_W-1:0]     largest_r, largest_nxt;
  logic                  bad_r, bad_nxt;

  logic              finish;
  logic [CODE_W-1:0] fin_code;
  logic              bad_now;
  logic [CODE_W-1:0] acc_shift;

  assign acc_shift = {acc_r[CODE_W-7:0], byte_value[5:0]};

  always_comb begin
    acc_nxt     = acc_r;
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    largest_nxt = largest_r;
    bad_nxt     = bad_r;
    finish      = 1'b0;
    fin_code    = '0;
    bad_now     = 1'b0;

    if (!bad_r) begin
      if (pend_r == '0) begin
        if (!byte_value[7]) begin
          finish   = 1'b1;
          fin_code = CODE_W'(byte_value);
        end else if (!byte_value[6]) begin
          bad_now = 1'b1;
        end else if (!byte_value[5]) begin
          acc_nxt = CODE_W'(byte_value[4:0]); pend_nxt = 3'd1;
        end else if (!byte_value[4]) begin
          acc_nxt = CODE_W'(byte_value[3:0]); pend_nxt = 3'd2;
        end else if (!byte_value[3]) begin
          acc_nxt = CODE_W'(byte_value[2:0]); pend_nxt = 3'd3;
        end else if (!byte_value[2]) begin
          acc_nxt = CODE_W'(byte_value[1:0]); pend_nxt = 3'd4;
        end else if (!byte_value[1]) begin
          acc_nxt = CODE_W'(byte_value[0]);   pend_nxt = 3'd5;
        end else begin
          bad_now = 1'b1;
        end
      end else if (byte_value[7:6] == 2'b10) begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 3'd1;
        if (pend_r == 3'd1) begin
          finish   = 1'b1;
          fin_code = acc_shift;
        end
      end else begin
        bad_now = 1'b1;
      end
      if (!bad_now && string_end && pend_nxt != '0) bad_now = 1'b1;
      if (finish) begin
        if (fin_code > largest_r) largest_nxt = fin_code;
        if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
      end
      if (bad_now) begin
        bad_nxt = 1'b1;
        finish  = 1'b0;
      end
    end

    has_result         = finish || bad_now || string_end;
    result.char_valid  = finish;
    result.code_point  = finish ? fin_code : '0;
    result.malformed   = bad_now;
    result.string_done = string_end;
    result.str_ok      = string_end && !bad_nxt;
    result.char_total  = (string_end && !bad_nxt) ? TOTAL_W'(cnt_nxt) : '0;
    result.width_class = (string_end && !bad_nxt) ? width_of(largest_nxt) : WCLASS_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pend_r    <= '0;
      cnt_r     <= '0;
      largest_r <= '0;
      bad_r     <= 1'b0;
    end else if (advance) begin
      if (string_end) begin
        // start the next string from a clean slate
        acc_r     <= '0;
        pend_r    <= '0;
        cnt_r     <= '0;
        largest_r <= '0;
        bad_r     <= 1'b0;
      end else begin
        acc_r     <= acc_nxt;
        pend_r    <= pend_nxt;
        cnt_r     <= cnt_nxt;
        largest_r <= largest_nxt;
        bad_r     <= bad_nxt;
      end
    end
  end

  a_char_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    advance && result.char_valid |-> !result.malformed)
    else $error("character completed on a malformed beat");

  a_class_iff_ok: assert property (@(posedge clk) disable iff (!rst_n)
    advance && has_result |-> ((result.width_class != WCLASS_NONE) == result.str_ok))
    else $error("width class disagrees with the string status");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && string_end |=> pend_r == '0 && !bad_r && cnt_r == '0)
    else $error("state not cleared after string end");

  a_bad_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    advance && bad_now && !string_end |=> bad_r)
    else $error("error flag lost within a string");

endmodule

// ===== rtl/utf8_to_ucs4_stream_decoder.sv =====
// UTF-8 (legacy 1..6 byte forms) to 31-bit UCS-4 stream decoder, top level.
// Input register, utf8dec_core decode, result register. Uses utf8dec_pkg.
//
// Usage:
//   Input channel: one UTF-8 byte per beat on in_byte_value, with
//   in_string_end high on the last byte of a string. in_valid/in_stall.
//   Result channel: out_* fields, out_valid/out_stall. A beat appears when a
//   character completes, when a byte is malformed, or on a string's last
//   byte; other bytes (continuations, bytes dropped after an error) give none.
//   Throughput: one byte per cycle while the result register is not held
//   by out_stall; a single decode stage lies between the two registers.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   per-string state. While out_valid and out_stall are both high the
//   result register holds; the input register still fills, and in_stall
//   rises once it is full. out_char_total and out_width_class are nonzero
//   only on a well-formed string end.
module utf8_to_ucs4_stream_decoder #(
  parameter int COUNT_BITS = utf8dec_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [utf8dec_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic                              in_string_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_char_valid,
  output logic [utf8dec_pkg::CODE_W-1:0]    out_code_point,
  output logic                              out_malformed,
  output logic                              out_string_done,
  output logic                              out_str_ok,
  output logic [utf8dec_pkg::TOTAL_W-1:0]   out_char_total,
  output logic [utf8dec_pkg::WCLASS_W-1:0]  out_width_class
);
  import utf8dec_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_end_r;
  logic              out_valid_r;
  result_t           res_r;

  logic    s2_ready, s1_adv, in_take, has_res;
  result_t res;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_take  = in_valid && !in_stall;

  utf8dec_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_adv),
    .byte_value (s1_byte_r),
    .string_end (s1_end_r),
    .has_result (has_res),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte_value;
      s1_end_r  <= in_string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_adv && has_res;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (s2_ready && s1_adv && has_res) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = res_r.char_valid;
  assign out_code_point  = res_r.code_point;
  assign out_malformed   = res_r.malformed;
  assign out_string_done = res_r.string_done;
  assign out_str_ok      = res_r.str_ok;
  assign out_char_total  = res_r.char_total;
  assign out_width_class = res_r.width_class;

endmodule
